// ===== rtl/piqst_pkg.sv =====
// shared types and constants for the point-in-quad-strip test core
`default_nettype none

package piqst_pkg;

   localparam int COORD_BITS = 24;
   localparam int IDX_BITS   = 12;
   localparam int MAX_POINTS = 1 << IDX_BITS;
   localparam int CNT_BITS   = IDX_BITS + 1;
   localparam int ROAD_SHIFT = 1;                       // road scale of two
   localparam int VTX_BITS   = COORD_BITS + ROAD_SHIFT;
   localparam int DIF_BITS   = VTX_BITS + 1;
   localparam int PRD_BITS   = 2 * DIF_BITS;

   localparam logic [CNT_BITS-1:0] RESET_STRIDE = CNT_BITS'(100);

   // configuration register indexes
   localparam logic CSR_POINT_COUNT = 1'b0;
   localparam logic CSR_QUAD_STRIDE = 1'b1;

   // request kinds
   localparam logic REQ_LOAD  = 1'b0;
   localparam logic REQ_QUERY = 1'b1;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] z;
      logic signed [COORD_BITS-1:0] x;
   } edge_type;

   typedef struct packed {
      logic signed [VTX_BITS-1:0] z;
      logic signed [VTX_BITS-1:0] x;
   } vtx_type;

   // strip corner, doubled
   function automatic vtx_type scale_vtx(input edge_type e);
      vtx_type v;
      v.x = {e.x, {ROAD_SHIFT{1'b0}}};
      v.z = {e.z, {ROAD_SHIFT{1'b0}}};
      return v;
   endfunction

   // query point, widened without scaling
   function automatic vtx_type widen_vtx(input edge_type e);
      vtx_type v;
      v.x = {{ROAD_SHIFT{e.x[COORD_BITS-1]}}, e.x};
      v.z = {{ROAD_SHIFT{e.z[COORD_BITS-1]}}, e.z};
      return v;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/point_in_quad_strip_test_core.sv =====
// top level of the point-in-quad-strip test core
`default_nettype none

// Point-in-quad-strip test core.
// req channel: each word is either a load (tuser = 0) that writes one right/left
//   edge point pair into the edge memories, or a query (tuser = 1) that asks
//   whether a point lies on the closed strip.
// rsp channel: one word per query, on_road in bit 0. Loads give no word.
// csr channel: point_count (index 0) and quad_stride (index 1); always ready,
//   written by the user only while the core is idle; the core does not enforce it.
// A query reads the strip one entry at a time from the edge memories (one read
//   port, registered read) and tests each quad as twelve cross-product sign
//   checks pushed through a four-stage difference/multiply/subtract pipe.
// Walk: a query reads and latches entry 0, then for each walked quad reads and
//   latches the next entry and runs the test steps, tests the closing quad and
//   passes through finish, where the answer becomes valid; the walk ends after
//   the first quad that hits. The walked quad count is about point_count /
//   quad_stride. An empty strip goes straight to finish. The core returns to
//   idle before the next word is taken.
// Only one query is in flight; req_tready is low while it runs. A finished
//   answer sits in the rsp output register; the core takes new words while it
//   waits, and a later answer waits until the receiver has taken the earlier.
// Reset (synchronous, active high) clears the control state, sets
//   point_count to 0 and quad_stride to 100. Edge memories are not cleared.

module point_in_quad_strip_test_core
   import piqst_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   // request channel
   input  wire logic                 req_tvalid,
   output logic                      req_tready,
   // point_index[11:0], right_x[35:12], right_z[59:36], left_x[83:60],
   // left_z[107:84], query_x[131:108], query_z[155:132], zero[159:156]
   input  wire logic [159:0]         req_tdata,
   input  wire logic [0:0]           req_tuser,   // req_type[0]
   // result channel
   output logic                      rsp_tvalid,
   input  wire logic                 rsp_tready,
   output logic [7:0]                rsp_tdata,   // on_road[0], zero[7:1]
   // configuration channel
   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire logic                 csr_index,
   input  wire logic [CNT_BITS-1:0]  csr_data
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_READ   = 3'd1;
   localparam logic [2:0] ST_LATCH  = 3'd2;
   localparam logic [2:0] ST_TEST   = 3'd3;
   localparam logic [2:0] ST_FINISH = 3'd4;

   localparam logic [3:0] STEP_COUNT = 4'd12;   // sign checks per quad
   localparam logic [3:0] STEP_LAST  = 4'd15;   // last issue + pipe depth
   localparam logic [3:0] TRI_STEPS  = 4'd6;

   // ---------------------------------------------------------------- fields
   logic                  req_fire;
   logic                  req_type;
   logic [IDX_BITS-1:0]   point_index;
   edge_type              right_w;
   edge_type              left_w;
   edge_type              query_w;

   assign req_fire    = req_tvalid && req_tready;
   assign req_type    = req_tuser[0];
   assign point_index = req_tdata[11:0];
   assign right_w.x   = req_tdata[35:12];
   assign right_w.z   = req_tdata[59:36];
   assign left_w.x    = req_tdata[83:60];
   assign left_w.z    = req_tdata[107:84];
   assign query_w.x   = req_tdata[131:108];
   assign query_w.z   = req_tdata[155:132];

   // ---------------------------------------------------------------- config
   logic [CNT_BITS-1:0]   point_count_ff;
   logic [CNT_BITS-1:0]   quad_stride_ff;
   logic [CNT_BITS-1:0]   size_w;
   logic [CNT_BITS-1:0]   stride_w;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         point_count_ff <= '0;
         quad_stride_ff <= RESET_STRIDE;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_POINT_COUNT: point_count_ff <= csr_data;
            CSR_QUAD_STRIDE: quad_stride_ff <= csr_data;
         endcase
      end
   end

   // counts beyond the memory clamp to its depth, a zero stride acts as one
   assign size_w   = (point_count_ff > CNT_BITS'(MAX_POINTS)) ? CNT_BITS'(MAX_POINTS)
                                                              : point_count_ff;
   assign stride_w = (quad_stride_ff == '0) ? CNT_BITS'(1) : quad_stride_ff;

   // ---------------------------------------------------------------- edge memories
   // loads write only in idle, read data is used only during a query: no overlap
   edge_type              right_mem [MAX_POINTS];
   edge_type              left_mem  [MAX_POINTS];
   edge_type              rd_right_ff;
   edge_type              rd_left_ff;
   logic [IDX_BITS-1:0]   idx_ff;

   always_ff @(posedge clock) begin
      if (req_fire && (req_type == REQ_LOAD)) begin
         right_mem[point_index] <= right_w;
         left_mem[point_index]  <= left_w;
      end
      rd_right_ff <= right_mem[idx_ff];
      rd_left_ff  <= left_mem[idx_ff];
   end

   // ---------------------------------------------------------------- walk control
   logic [2:0]            state_ff, state_in;
   logic [IDX_BITS-1:0]   idx_in;
   logic                  first_ff, first_in;
   logic                  closing_ff, closing_in;
   logic [3:0]            k_ff, k_in;
   logic                  hit_ff, hit_in;
   edge_type              p_ff, p_in;
   edge_type              ri_ff, ri_in, li_ff, li_in;   // corners at index i
   edge_type              rj_ff, rj_in, lj_ff, lj_in;   // corners at index j
   edge_type              r0_ff, r0_in, l0_ff, l0_in;   // entry 0 for the closing quad
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  on_road_ff, on_road_in;
   logic [1:0]            tri_ok_ff;
   logic                  more_w;
   logic [IDX_BITS+1:0]   next_sum_w;

   assign next_sum_w = {2'b00, idx_ff} + {1'b0, stride_w};
   assign more_w     = next_sum_w < {1'b0, size_w};

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'b0, on_road_ff};

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      first_in     = first_ff;
      closing_in   = closing_ff;
      k_in         = k_ff;
      hit_in       = hit_ff;
      p_in         = p_ff;
      ri_in        = ri_ff;
      li_in        = li_ff;
      rj_in        = rj_ff;
      lj_in        = lj_ff;
      r0_in        = r0_ff;
      l0_in        = l0_ff;
      on_road_in   = on_road_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire && (req_type == REQ_QUERY)) begin
               p_in       = query_w;
               idx_in     = '0;
               first_in   = 1'b1;
               closing_in = 1'b0;
               if (size_w == '0) begin
                  hit_in   = 1'b0;
                  state_in = ST_FINISH;
               end else begin
                  state_in = ST_READ;
               end
            end
         end
         ST_READ: begin
            state_in = ST_LATCH;
         end
         ST_LATCH: begin
            k_in = '0;
            if (first_ff) begin
               ri_in    = rd_right_ff;
               li_in    = rd_left_ff;
               r0_in    = rd_right_ff;
               l0_in    = rd_left_ff;
               first_in = 1'b0;
               if (more_w) begin
                  idx_in   = next_sum_w[IDX_BITS-1:0];
                  state_in = ST_READ;
               end else begin
                  // short strip: only the degenerate closing quad
                  rj_in      = rd_right_ff;
                  lj_in      = rd_left_ff;
                  closing_in = 1'b1;
                  state_in   = ST_TEST;
               end
            end else begin
               rj_in    = rd_right_ff;
               lj_in    = rd_left_ff;
               state_in = ST_TEST;
            end
         end
         ST_TEST: begin
            k_in = k_ff + 4'd1;
            if (k_ff == STEP_LAST) begin
               if (tri_ok_ff != 2'b00) begin
                  hit_in   = 1'b1;
                  state_in = ST_FINISH;
               end else if (closing_ff) begin
                  hit_in   = 1'b0;
                  state_in = ST_FINISH;
               end else begin
                  ri_in = rj_ff;
                  li_in = lj_ff;
                  if (more_w) begin
                     idx_in   = next_sum_w[IDX_BITS-1:0];
                     state_in = ST_READ;
                  end else begin
                     // last visited index joins back to entry 0
                     rj_in      = r0_ff;
                     lj_in      = l0_ff;
                     closing_in = 1'b1;
                     k_in       = '0;
                  end
               end
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               on_road_in   = hit_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         k_ff         <= '0;
         first_ff     <= 1'b0;
         closing_ff   <= 1'b0;
         idx_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         k_ff         <= k_in;
         first_ff     <= first_in;
         closing_ff   <= closing_in;
         idx_ff       <= idx_in;
      end
      hit_ff     <= hit_in;
      p_ff       <= p_in;
      ri_ff      <= ri_in;
      li_ff      <= li_in;
      rj_ff      <= rj_in;
      lj_ff      <= lj_in;
      r0_ff      <= r0_in;
      l0_ff      <= l0_in;
      on_road_ff <= on_road_in;
   end

   // ---------------------------------------------------------------- sign pipe
   // step k: triangle k/6; pairs of steps share an edge, even = query point,
   // odd = opposite vertex
   logic                  tri1_w;
   logic [3:0]            ek_w;
   vtx_type               va_w, vb_w, vc_w;
   vtx_type               s_w, t_w, v_w, q_w, pv_w;
   logic                  issue_w;

   assign tri1_w  = (k_ff >= TRI_STEPS);
   assign ek_w    = tri1_w ? (k_ff - TRI_STEPS) : k_ff;
   assign issue_w = (state_ff == ST_TEST) && (k_ff < STEP_COUNT);
   assign pv_w    = widen_vtx(p_ff);

   always_comb begin
      va_w = tri1_w ? scale_vtx(lj_ff) : scale_vtx(ri_ff);
      vb_w = tri1_w ? scale_vtx(rj_ff) : scale_vtx(li_ff);
      vc_w = tri1_w ? scale_vtx(ri_ff) : scale_vtx(lj_ff);
      unique case (ek_w[2:1])
         2'd0: begin
            s_w = vb_w; t_w = vc_w; v_w = va_w;
         end
         2'd1: begin
            s_w = va_w; t_w = vc_w; v_w = vb_w;
         end
         default: begin
            s_w = va_w; t_w = vb_w; v_w = vc_w;
         end
      endcase
      q_w = ek_w[0] ? v_w : pv_w;
   end

   // stage 1: edge and point differences
   logic                       dif_vld_ff;
   logic                       dif_odd_ff, dif_tri_ff;
   logic signed [DIF_BITS-1:0] dif_ux_ff, dif_uz_ff, dif_vx_ff, dif_vz_ff;
   // stage 2: the two products
   logic                       mul_vld_ff;
   logic                       mul_odd_ff, mul_tri_ff;
   logic signed [PRD_BITS-1:0] prd_a_ff, prd_b_ff;
   // stage 3: sign of the cross product
   logic                       sgn_vld_ff;
   logic                       sgn_odd_ff, sgn_tri_ff;
   logic                       sgn_pos_ff, sgn_neg_ff;
   logic signed [PRD_BITS:0]   cross_w;
   // stage 4: held query-point sign of the current edge
   logic                       psg_pos_ff, psg_neg_ff;

   assign cross_w = {prd_a_ff[PRD_BITS-1], prd_a_ff} - {prd_b_ff[PRD_BITS-1], prd_b_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         dif_vld_ff <= 1'b0;
         mul_vld_ff <= 1'b0;
         sgn_vld_ff <= 1'b0;
      end else begin
         dif_vld_ff <= issue_w;
         mul_vld_ff <= dif_vld_ff;
         sgn_vld_ff <= mul_vld_ff;
      end
      dif_odd_ff <= ek_w[0];
      dif_tri_ff <= tri1_w;
      dif_ux_ff  <= {t_w.x[VTX_BITS-1], t_w.x} - {s_w.x[VTX_BITS-1], s_w.x};
      dif_uz_ff  <= {t_w.z[VTX_BITS-1], t_w.z} - {s_w.z[VTX_BITS-1], s_w.z};
      dif_vx_ff  <= {q_w.x[VTX_BITS-1], q_w.x} - {s_w.x[VTX_BITS-1], s_w.x};
      dif_vz_ff  <= {q_w.z[VTX_BITS-1], q_w.z} - {s_w.z[VTX_BITS-1], s_w.z};

      mul_odd_ff <= dif_odd_ff;
      mul_tri_ff <= dif_tri_ff;
      prd_a_ff   <= dif_uz_ff * dif_vx_ff;
      prd_b_ff   <= dif_ux_ff * dif_vz_ff;

      sgn_odd_ff <= mul_odd_ff;
      sgn_tri_ff <= mul_tri_ff;
      sgn_neg_ff <= cross_w[PRD_BITS];
      sgn_pos_ff <= !cross_w[PRD_BITS] && (cross_w != '0);

      // a zero sign agrees with anything; strictly opposite signs clear the triangle
      if ((state_ff == ST_TEST) && (k_ff == '0)) begin
         tri_ok_ff <= 2'b11;
      end else if (sgn_vld_ff) begin
         if (!sgn_odd_ff) begin
            psg_pos_ff <= sgn_pos_ff;
            psg_neg_ff <= sgn_neg_ff;
         end else if ((psg_pos_ff && sgn_neg_ff) || (psg_neg_ff && sgn_pos_ff)) begin
            tri_ok_ff[sgn_tri_ff] <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------- checks
   a_pipe_empty_at_quad_start: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_TEST) && (k_ff == '0) |-> !dif_vld_ff && !mul_vld_ff && !sgn_vld_ff)
      else $error("sign pipe not drained at quad start");

   a_signs_only_in_test: assert property (@(posedge clock) disable iff (reset)
      sgn_vld_ff |-> (state_ff == ST_TEST))
      else $error("sign result outside quad test");

   a_answer_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_FINISH))
      else $error("answer raised outside finish");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH) && rsp_valid_ff && !rsp_tready |=> (state_ff == ST_FINISH))
      else $error("answer would overwrite a waiting word");

endmodule

`default_nettype wire
